/* rtl/core/ptse_pkg.sv */
// ----------------------------------------------------------------------------
// ptse_pkg
// Shared types and codes for the sparse polynomial term store and evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptse_pkg;

  // Width of the exponent field and the number of exponents it can name.
  localparam int unsigned ExpW    = 6;
  localparam int unsigned ExpSpan = 2 ** ExpW;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned ValueW  = 64;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EVALUATED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic [ExpW-1:0]         exponent;
    logic signed [CoefW-1:0] coefficient;
    logic signed [CoefW-1:0] point;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [ValueW-1:0] value;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/ptse_if.sv */
// ----------------------------------------------------------------------------
// ptse_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptse_in_if;
  import ptse_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptse_out_if;
  import ptse_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ptse_ram.sv */
// ----------------------------------------------------------------------------
// ptse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/polynomial_term_store_evaluator_core.sv */
// An add or remove result passes through S_FIN into the output register; adding to a
// present term first passes S_ADD_WR to read and rewrite the coefficient. Evaluation walks
// the S = min(TERM_SLOTS, 64) slots from the top by Horner's rule with one shared 32x32
// multiplier, two passes per slot. One item is in flight at a time; the next is accepted
// the cycle after the result has moved to the output register.
// Reset clears every present flag at once; coefficient RAM contents are not reset.
// ----------------------------------------------------------------------------
// polynomial_term_store_evaluator_core
// Sparse polynomial store: add or remove terms by exponent, and evaluate the
// polynomial at a point with a sequenced shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_term_store_evaluator_core #(
  parameter int unsigned TERM_SLOTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ptse_in_if.sink     in_i,
  ptse_out_if.source  out_o
);
  import ptse_pkg::*;

  // Slots above the reach of the exponent field can never be written.
  localparam int unsigned Slots = (TERM_SLOTS < ExpSpan) ? TERM_SLOTS : ExpSpan;
  localparam int unsigned IdxW  = $clog2(Slots);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADD_WR = 5'b00010,
    S_EVAL_A = 5'b00100,
    S_EVAL_B = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [Slots-1:0]    present_q, present_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     exp_q, exp_d;
  logic [CoefW-1:0]    coef_q, coef_d;
  logic [CoefW-1:0]    x_q, x_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [ValueW-1:0]   prod_q, prod_d;
  logic [2:0]          res_status_q, res_status_d;
  logic [ValueW-1:0]   res_value_q, res_value_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                accept;
  logic                in_range;
  logic [IdxW-1:0]     in_idx;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [CoefW-1:0]    ram_wdata;
  logic                ram_re;
  logic [IdxW-1:0]     ram_raddr;
  logic [CoefW-1:0]    ram_rdata;

  logic [CoefW-1:0]    mul_a;
  logic [CoefW-1:0]    mul_b;
  logic [ValueW-1:0]   mul_p;
  logic [CoefW-1:0]    hi_part;
  logic [ValueW-1:0]   term;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign in_range   = ({1'b0, in_i.data.exponent} < (ExpW+1)'(Slots));
  assign in_idx     = in_i.data.exponent[IdxW-1:0];

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The one shared multiplier: x times the low or the high half of the accumulator.
  assign mul_a = x_q;
  assign mul_b = (state_q == S_EVAL_B) ? acc_q[ValueW-1:CoefW] : acc_q[CoefW-1:0];
  assign mul_p = mul_a * mul_b;

  // Upper word of acc * sext(x): a negative x subtracts the low half once more.
  assign hi_part = mul_p[CoefW-1:0] - (x_q[CoefW-1] ? acc_q[CoefW-1:0] : '0);
  assign term    = present_q[idx_q] ? {{(ValueW-CoefW){ram_rdata[CoefW-1]}}, ram_rdata}
                                    : '0;

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    idx_d        = idx_q;
    exp_d        = exp_q;
    coef_d       = coef_q;
    x_d          = x_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    ram_we       = 1'b0;
    ram_waddr    = in_idx;
    ram_wdata    = in_i.data.coefficient;
    ram_re       = 1'b0;
    ram_raddr    = in_idx;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_NOT_FOUND;
          res_value_d  = '0;
          state_d      = S_FIN;
          case (mode_e'(in_i.data.mode))
            MODE_ADD: begin
              if (in_range) begin
                if (present_q[in_idx]) begin
                  ram_re  = 1'b1;
                  exp_d   = in_idx;
                  coef_d  = in_i.data.coefficient;
                  state_d = S_ADD_WR;
                end else begin
                  ram_we             = 1'b1;
                  present_d[in_idx]  = 1'b1;
                  res_status_d       = ST_NEW;
                end
              end
            end
            MODE_REMOVE: begin
              if (in_range && present_q[in_idx]) begin
                present_d[in_idx] = 1'b0;
                res_status_d      = ST_REMOVED;
              end
            end
            MODE_EVAL: begin
              x_d     = in_i.data.point;
              acc_d   = '0;
              idx_d   = IdxW'(Slots - 1);
              state_d = S_EVAL_A;
            end
            default: begin
              res_status_d = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_ADD_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = exp_q;
        ram_wdata    = ram_rdata + coef_q;
        res_status_d = ST_ADDED;
        state_d      = S_FIN;
      end
      S_EVAL_A: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        prod_d    = mul_p;
        state_d   = S_EVAL_B;
      end
      S_EVAL_B: begin
        acc_d = prod_q + {hi_part, {CoefW{1'b0}}} + term;
        if (idx_q == '0) begin
          res_status_d = ST_EVALUATED;
          res_value_d  = acc_d;
          state_d      = S_FIN;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_EVAL_A;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_FIN) && (!out_valid_q || out_o.ready)) begin
      out_valid_d       = 1'b1;
      out_data_d.status = res_status_q;
      out_data_d.value  = res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    exp_q        <= exp_d;
    coef_q       <= coef_d;
    x_q          <= x_d;
    acc_q        <= acc_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_data_q   <= out_data_d;
  end

  ptse_ram #(
    .WIDTH (CoefW),
    .DEPTH (Slots)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
